// ----- design/gmit_pkg.sv -----
`default_nettype none

package gmit_pkg;

   // Default sizes of the set; the top level takes them as parameter defaults.
   localparam int DEF_MAX_MEMBERS = 16;
   localparam int DEF_INDEX_BITS  = 8;

   // Widths fixed by the transaction fields.
   localparam int OPCODE_BITS = 3;
   localparam int PORT_INDEX_BITS = 8;
   localparam int PORT_COUNT_BITS = 5;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_ADD        = 3'd0,
      OP_REMOVE     = 3'd1,
      OP_CONTAINS   = 3'd2,
      OP_CHAN_REMOV = 3'd3,
      OP_CHAN_MOVED = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

// ----- design/group_member_index_table_unit.sv -----
`default_nettype none

// Channel   Direction  Ports
// req       in         req_valid, req_stall, req_opcode, req_track_index, req_target_index
// rsp       out        rsp_valid, rsp_stall, rsp_ok, rsp_member_count
//
// Each item is walked by the single entry unit, which reads one member from the
// entry memory each cycle over a pipelined walk of the set and writes back the
// entries that the opcode updates or moves down; no new item is taken until the
// result of the last one has been taken. Unused opcodes and an empty set skip the walk.
// Synchronous reset empties the set at once; entry contents are left as they are.
// While a result is stalled the block holds it and takes no new transaction.

module group_member_index_table_unit #(
   parameter int MAX_MEMBERS = gmit_pkg::DEF_MAX_MEMBERS,
   parameter int INDEX_BITS  = gmit_pkg::DEF_INDEX_BITS
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      req_valid,
   output logic                                     req_stall,
   input  wire  [gmit_pkg::OPCODE_BITS-1:0]         req_opcode,
   input  wire  [gmit_pkg::PORT_INDEX_BITS-1:0]     req_track_index,
   input  wire  [gmit_pkg::PORT_INDEX_BITS-1:0]     req_target_index,
   output logic                                     rsp_valid,
   input  wire                                      rsp_stall,
   output logic                                     rsp_ok,
   output logic [gmit_pkg::PORT_COUNT_BITS-1:0]     rsp_member_count
);

   localparam int COUNT_BITS = $clog2(MAX_MEMBERS + 1);
   localparam int AW         = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
   localparam int PB         = gmit_pkg::PORT_INDEX_BITS;
   localparam int CB         = gmit_pkg::PORT_COUNT_BITS;

   gmit_pkg::state_type    state_ff, state_in;
   gmit_pkg::op_type       op_ff;
   logic [INDEX_BITS-1:0]  a_ff, b_ff;
   logic [COUNT_BITS-1:0]  issue_ptr_ff, issue_ptr_in;
   logic                   data_vld_ff, data_vld_in;
   logic [AW-1:0]          data_ptr_ff, data_ptr_in;
   logic                   found_ff, found_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   ok_ff, ok_in;
   logic [INDEX_BITS-1:0]  rd_data_ff;
   logic [INDEX_BITS-1:0]  member_mem_ff [MAX_MEMBERS];

   logic                   req_accept;
   logic                   op_known;
   logic                   rd_en;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [INDEX_BITS-1:0]  wr_data;
   logic [INDEX_BITS-1:0]  req_a, req_b;
   logic [INDEX_BITS+PB-1:0] track_ext, target_ext;
   logic [COUNT_BITS+CB-1:0] count_ext;
   logic                   hit;

   // Index bits above INDEX_BITS are dropped; a narrower port is zero-extended.
   assign track_ext  = {{INDEX_BITS{1'b0}}, req_track_index};
   assign target_ext = {{INDEX_BITS{1'b0}}, req_target_index};
   assign req_a      = track_ext[INDEX_BITS-1:0];
   assign req_b      = target_ext[INDEX_BITS-1:0];

   assign req_accept = req_valid && !req_stall;
   assign op_known   = (req_opcode == gmit_pkg::OP_ADD)
                    || (req_opcode == gmit_pkg::OP_REMOVE)
                    || (req_opcode == gmit_pkg::OP_CONTAINS)
                    || (req_opcode == gmit_pkg::OP_CHAN_REMOV)
                    || (req_opcode == gmit_pkg::OP_CHAN_MOVED);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gmit_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (op_known && (count_ff != '0)) begin
                  state_in = gmit_pkg::ST_SCAN;
               end else begin
                  state_in = gmit_pkg::ST_FINISH;
               end
            end
         end
         gmit_pkg::ST_SCAN: begin
            if ((issue_ptr_ff == count_ff) && !data_vld_ff) begin
               state_in = gmit_pkg::ST_FINISH;
            end
         end
         gmit_pkg::ST_FINISH: begin
            state_in = gmit_pkg::ST_RESP;
         end
         gmit_pkg::ST_RESP: begin
            if (!rsp_stall) begin
               state_in = gmit_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gmit_pkg::ST_IDLE;
         end
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req_stall = (state_ff != gmit_pkg::ST_IDLE);
      rsp_valid = (state_ff == gmit_pkg::ST_RESP);
   end

   assign rsp_ok           = ok_ff;
   assign count_ext        = {{CB{1'b0}}, count_ff};
   assign rsp_member_count = count_ext[CB-1:0];

   // Entry unit: one member is read ahead while the previous one is updated, and
   // the update goes to the same slot or, once the match is deleted, one slot lower.
   always_comb begin
      issue_ptr_in = issue_ptr_ff;
      data_vld_in  = 1'b0;
      data_ptr_in  = data_ptr_ff;
      found_in     = found_ff;
      count_in     = count_ff;
      ok_in        = ok_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = data_ptr_ff;
      wr_data      = rd_data_ff;
      hit          = (rd_data_ff == a_ff);

      case (state_ff)
         gmit_pkg::ST_IDLE: begin
            issue_ptr_in = '0;
            found_in     = 1'b0;
         end
         gmit_pkg::ST_SCAN: begin
            if (issue_ptr_ff != count_ff) begin
               rd_en        = 1'b1;
               data_vld_in  = 1'b1;
               data_ptr_in  = issue_ptr_ff[AW-1:0];
               issue_ptr_in = issue_ptr_ff + COUNT_BITS'(1);
            end
            if (data_vld_ff) begin
               case (op_ff)
                  gmit_pkg::OP_ADD, gmit_pkg::OP_CONTAINS: begin
                     if (hit) begin
                        found_in = 1'b1;
                     end
                  end
                  gmit_pkg::OP_REMOVE, gmit_pkg::OP_CHAN_REMOV: begin
                     if (op_ff == gmit_pkg::OP_CHAN_REMOV && rd_data_ff > a_ff) begin
                        wr_data = rd_data_ff - INDEX_BITS'(1);
                     end
                     if (found_ff) begin
                        wr_en   = 1'b1;
                        wr_addr = data_ptr_ff - AW'(1);
                     end else if (hit) begin
                        found_in = 1'b1;
                     end else begin
                        wr_en = (op_ff == gmit_pkg::OP_CHAN_REMOV);
                     end
                  end
                  gmit_pkg::OP_CHAN_MOVED: begin
                     wr_en = 1'b1;
                     if (hit) begin
                        found_in = 1'b1;
                        wr_data  = b_ff;
                     end else if (a_ff < b_ff) begin
                        if (rd_data_ff > a_ff && rd_data_ff <= b_ff) begin
                           wr_data = rd_data_ff - INDEX_BITS'(1);
                        end
                     end else if (rd_data_ff >= b_ff && rd_data_ff < a_ff) begin
                        wr_data = rd_data_ff + INDEX_BITS'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         gmit_pkg::ST_FINISH: begin
            case (op_ff)
               gmit_pkg::OP_ADD: begin
                  if (!found_ff && (count_ff < COUNT_BITS'(MAX_MEMBERS))) begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[AW-1:0];
                     wr_data  = a_ff;
                     count_in = count_ff + COUNT_BITS'(1);
                     ok_in    = 1'b1;
                  end else begin
                     ok_in = 1'b0;
                  end
               end
               gmit_pkg::OP_REMOVE, gmit_pkg::OP_CHAN_REMOV: begin
                  ok_in = found_ff;
                  if (found_ff) begin
                     count_in = count_ff - COUNT_BITS'(1);
                  end
               end
               gmit_pkg::OP_CONTAINS, gmit_pkg::OP_CHAN_MOVED: begin
                  ok_in = found_ff;
               end
               default: begin
                  ok_in = 1'b0;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gmit_pkg::ST_IDLE;
         issue_ptr_ff <= '0;
         data_vld_ff  <= 1'b0;
         found_ff     <= 1'b0;
         count_ff     <= '0;
         ok_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ptr_ff <= issue_ptr_in;
         data_vld_ff  <= data_vld_in;
         found_ff     <= found_in;
         count_ff     <= count_in;
         ok_ff        <= ok_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ptr_ff <= data_ptr_in;
      if (req_accept) begin
         op_ff <= gmit_pkg::op_type'(req_opcode);
         a_ff  <= req_a;
         b_ff  <= req_b;
      end
   end

   // Entry memory: one read and one write port, read data registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= member_mem_ff[issue_ptr_ff[AW-1:0]];
      end
      if (wr_en) begin
         member_mem_ff[wr_addr] <= wr_data;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(MAX_MEMBERS))
      else $error("member count exceeds the set size");

   a_count_only_at_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff != gmit_pkg::ST_FINISH) |=> $stable(count_ff))
      else $error("member count changed outside the finish step");

   a_scan_write_in_set: assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff == gmit_pkg::ST_SCAN) |-> (wr_addr < count_ff))
      else $error("walk wrote an entry outside the set");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != gmit_pkg::ST_IDLE))
      else $error("transaction accepted without starting work");

   a_no_accept_with_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_accept)
      else $error("request taken while a result is pending");
`endif

endmodule

`default_nettype wire
